FILE: src/bept_pkg.sv
// shared types, constants and reset values for the blob edge pan/tilt tracker
// depends on nothing; used by every file of the block

package bept_pkg;

  // image size bounds for tracking
  localparam int unsigned MaxColsDef = 1024;
  localparam int unsigned MaxRowsDef = 1024;

  // foreground pixel value
  localparam logic [7:0] PixSet = 8'd255;

  // frame result queue depth
  localparam int unsigned QDepth = 4;

  // register reset values
  localparam logic [9:0]  CenterColRst = 10'd400;
  localparam logic [9:0]  CenterRowRst = 10'd240;
  localparam logic [7:0]  ToleranceRst = 8'd10;
  localparam logic [7:0]  MoveStepRst  = 8'd10;
  localparam logic [11:0] PanMinRst    = 12'd500;
  localparam logic [11:0] PanMaxRst    = 12'd2500;
  localparam logic [11:0] TiltMinRst   = 12'd1500;
  localparam logic [11:0] TiltMaxRst   = 12'd2166;

  // servo reset positions
  localparam logic [11:0] PanPosRst  = 12'd1500;
  localparam logic [11:0] TiltPosRst = 12'd1800;
  localparam logic [11:0] PosMax     = 12'd4095;

  // register indexes
  typedef enum logic [2:0] {
    REG_CENTER_COL = 3'd0,
    REG_CENTER_ROW = 3'd1,
    REG_TOLERANCE  = 3'd2,
    REG_MOVE_STEP  = 3'd3,
    REG_PAN_MIN    = 3'd4,
    REG_PAN_MAX    = 3'd5,
    REG_TILT_MIN   = 3'd6,
    REG_TILT_MAX   = 3'd7
  } reg_idx_e;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_PAN    = 2'd0,
    KIND_TILT   = 2'd1,
    KIND_STATUS = 2'd2
  } item_kind_e;

  // emit phase of the output serialiser
  typedef enum logic [2:0] {
    PH_PAN  = 3'b001,
    PH_TILT = 3'b010,
    PH_STAT = 3'b100
  } phase_e;

  // input word
  typedef struct packed {
    logic [9:0] pix_row;
    logic [9:0] pix_col;
    logic [7:0] pix_value;
    logic       frame_end;
  } pix_t;

  // result word
  typedef struct packed {
    item_kind_e  item_kind;
    logic [11:0] servo_position;
    logic        centered;
    logic        last_of_run;
  } result_t;

  // configuration registers
  typedef struct packed {
    logic [9:0]  center_col;
    logic [9:0]  center_row;
    logic [7:0]  tolerance;
    logic [7:0]  move_step;
    logic [11:0] pan_min;
    logic [11:0] pan_max;
    logic [11:0] tilt_min;
    logic [11:0] tilt_max;
  } cfg_t;

  // edge points of one finished frame
  typedef struct packed {
    logic       vld;
    logic [9:0] lx;
    logic [9:0] ly;
    logic [9:0] rx;
  } snap_t;

  // servo results of one frame
  typedef struct packed {
    logic        pan_cmd;
    logic [11:0] pan_pos;
    logic        tilt_cmd;
    logic [11:0] tilt_pos;
    logic        centered;
  } frame_res_t;

endpackage

FILE: src/bept_track.sv
// pixel input register and per-frame edge point tracking
// depends on bept_pkg

module bept_track #(
  parameter int unsigned MAX_COLS = bept_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = bept_pkg::MaxRowsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  bept_pkg::pix_t pix_i,
  output logic           fe_busy_o,
  output bept_pkg::snap_t snap_o
);

  logic           pvld_q;
  bept_pkg::pix_t pix_q;
  logic           found_q, found_d;
  logic [9:0]     lcol_q, lrow_q, rcol_q, rrow_q;
  logic [9:0]     lcol_d, lrow_d, rcol_d, rrow_d;
  bept_pkg::snap_t snap_q, snap_d;
  logic           hit;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pix_q <= pix_i;
    end
  end

  assign hit = pvld_q && (pix_q.pix_value == bept_pkg::PixSet)
               && (32'(pix_q.pix_col) < MAX_COLS) && (32'(pix_q.pix_row) < MAX_ROWS);

  // edge point update, snapshot and clear on frame end
  always_comb begin
    found_d = found_q;
    lcol_d  = lcol_q;
    lrow_d  = lrow_q;
    rcol_d  = rcol_q;
    rrow_d  = rrow_q;
    if (hit) begin
      found_d = 1'b1;
      if (!found_q) begin
        lcol_d = pix_q.pix_col;
        lrow_d = pix_q.pix_row;
        rcol_d = pix_q.pix_col;
        rrow_d = pix_q.pix_row;
      end else begin
        if (pix_q.pix_col < lcol_q || (pix_q.pix_col == lcol_q && pix_q.pix_row < lrow_q)) begin
          lcol_d = pix_q.pix_col;
          lrow_d = pix_q.pix_row;
        end
        if (pix_q.pix_col > rcol_q || (pix_q.pix_col == rcol_q && pix_q.pix_row < rrow_q)) begin
          rcol_d = pix_q.pix_col;
          rrow_d = pix_q.pix_row;
        end
      end
    end
    snap_d.vld = pvld_q && pix_q.frame_end;
    snap_d.lx  = lcol_d;
    snap_d.ly  = lrow_d;
    snap_d.rx  = rcol_d;
    if (snap_d.vld) begin
      found_d = 1'b0;
      lcol_d  = '0;
      lrow_d  = '0;
      rcol_d  = '0;
      rrow_d  = '0;
    end
  end

  // edge point registers and frame snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      lcol_q  <= '0;
      lrow_q  <= '0;
      rcol_q  <= '0;
      rrow_q  <= '0;
      snap_q  <= '0;
    end else begin
      found_q    <= found_d;
      lcol_q     <= lcol_d;
      lrow_q     <= lrow_d;
      rcol_q     <= rcol_d;
      rrow_q     <= rrow_d;
      snap_q.vld <= snap_d.vld;
      if (snap_d.vld) begin
        snap_q.lx <= snap_d.lx;
        snap_q.ly <= snap_d.ly;
        snap_q.rx <= snap_d.rx;
      end
    end
  end

  assign fe_busy_o = pvld_q && pix_q.frame_end;
  assign snap_o    = snap_q;

endmodule

FILE: src/bept_servo.sv
// servo steps per frame, frame result queue and result word serialiser
// depends on bept_pkg

module bept_servo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bept_pkg::cfg_t       cfg_i,
  input  bept_pkg::snap_t      snap_i,
  output logic [2:0]           cnt_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bept_pkg::result_t    out_data_o
);

  localparam int unsigned PtrW = $clog2(bept_pkg::QDepth);

  logic [11:0] pan_q, pan_d, tilt_q, tilt_d;
  logic [11:0] s_lr, cc2, t2;
  logic [10:0] ly_t, cr_t;
  logic [9:0]  dx, dy;
  logic        pan_up, pan_dn, tilt_dn, tilt_up, pan_fire, tilt_fire, cen;
  logic [11:0] pan_new, tilt_new;
  logic [12:0] pan_inc, tilt_inc;
  bept_pkg::frame_res_t res;

  bept_pkg::frame_res_t q_mem [bept_pkg::QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [2:0]      cnt_q;
  logic            push, pop;
  bept_pkg::frame_res_t head;

  bept_pkg::phase_e  ph_q, ph_d;
  logic              out_vld_q, load;
  bept_pkg::result_t out_q, out_d;

  // dead band tests, halved width compared after doubling both sides
  assign s_lr = {2'b00, snap_i.lx} + {2'b00, snap_i.rx};
  assign cc2  = {1'b0, cfg_i.center_col, 1'b0};
  assign t2   = {3'b000, cfg_i.tolerance, 1'b0};
  assign ly_t = {1'b0, snap_i.ly} + {3'b000, cfg_i.tolerance};
  assign cr_t = {1'b0, cfg_i.center_row} + {3'b000, cfg_i.tolerance};
  assign pan_up  = (s_lr + t2) < cc2;
  assign pan_dn  = s_lr > (cc2 + t2);
  assign tilt_dn = ly_t < {1'b0, cfg_i.center_row};
  assign tilt_up = {1'b0, snap_i.ly} > cr_t;
  assign dx = (snap_i.lx >= cfg_i.center_col) ? snap_i.lx - cfg_i.center_col
                                              : cfg_i.center_col - snap_i.lx;
  assign dy = (snap_i.ly >= cfg_i.center_row) ? snap_i.ly - cfg_i.center_row
                                              : cfg_i.center_row - snap_i.ly;
  assign cen = (({1'b0, dx, 1'b0} + {2'b00, snap_i.lx}) < ({2'b00, snap_i.rx} + t2))
               && (dy < {2'b00, cfg_i.tolerance});

  // saturating servo moves; pan up and pan down never both hold, nor the tilt pair
  assign pan_inc  = {1'b0, pan_q} + {5'b0, cfg_i.move_step};
  assign tilt_inc = {1'b0, tilt_q} + {5'b0, cfg_i.move_step};

  always_comb begin
    pan_fire  = (pan_up && pan_q < cfg_i.pan_max) || (pan_dn && pan_q > cfg_i.pan_min);
    tilt_fire = (tilt_dn && tilt_q > cfg_i.tilt_min) || (tilt_up && tilt_q < cfg_i.tilt_max);
    if (pan_up) begin
      pan_new = pan_inc[12] ? bept_pkg::PosMax : pan_inc[11:0];
    end else begin
      pan_new = (pan_q > {4'b0, cfg_i.move_step}) ? pan_q - {4'b0, cfg_i.move_step} : '0;
    end
    if (tilt_up) begin
      tilt_new = tilt_inc[12] ? bept_pkg::PosMax : tilt_inc[11:0];
    end else begin
      tilt_new = (tilt_q > {4'b0, cfg_i.move_step}) ? tilt_q - {4'b0, cfg_i.move_step} : '0;
    end
    pan_d  = (snap_i.vld && pan_fire) ? pan_new : pan_q;
    tilt_d = (snap_i.vld && tilt_fire) ? tilt_new : tilt_q;
    res.pan_cmd  = pan_fire;
    res.pan_pos  = pan_d;
    res.tilt_cmd = tilt_fire;
    res.tilt_pos = tilt_d;
    res.centered = cen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q  <= bept_pkg::PanPosRst;
      tilt_q <= bept_pkg::TiltPosRst;
    end else begin
      pan_q  <= pan_d;
      tilt_q <= tilt_d;
    end
  end

  // frame result queue; the input stall keeps room for every frame in flight
  assign push = snap_i.vld;
  assign head = q_mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {2'b00, push} - {2'b00, pop};
    end
  end

  // serialiser: pan command, tilt command, then status word
  assign load = (cnt_q != '0) && (!out_vld_q || !out_stall_i);

  always_comb begin
    out_d = out_q;
    ph_d  = ph_q;
    pop   = 1'b0;
    if (load) begin
      out_d.centered    = 1'b0;
      out_d.last_of_run = 1'b0;
      if (ph_q == bept_pkg::PH_PAN && head.pan_cmd) begin
        out_d.item_kind      = bept_pkg::KIND_PAN;
        out_d.servo_position = head.pan_pos;
        ph_d                 = bept_pkg::PH_TILT;
      end else if (ph_q != bept_pkg::PH_STAT && head.tilt_cmd) begin
        out_d.item_kind      = bept_pkg::KIND_TILT;
        out_d.servo_position = head.tilt_pos;
        ph_d                 = bept_pkg::PH_STAT;
      end else begin
        out_d.item_kind      = bept_pkg::KIND_STATUS;
        out_d.servo_position = head.pan_pos;
        out_d.centered       = head.centered;
        out_d.last_of_run    = 1'b1;
        ph_d                 = bept_pkg::PH_PAN;
        pop                  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= bept_pkg::PH_PAN;
      out_vld_q <= 1'b0;
    end else begin
      ph_q <= ph_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign cnt_o       = cnt_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(bept_pkg::QDepth))
    else $error("frame result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'(bept_pkg::QDepth)) |-> !push)
    else $error("frame result pushed into a full queue");

  // a frame part way through its words is still at the queue head
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != bept_pkg::PH_PAN) |-> (cnt_q != '0))
    else $error("serialiser mid-frame with empty queue");

  // a status word always frees its queue entry
  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_q.item_kind == bept_pkg::KIND_STATUS && out_q.last_of_run))
    else $error("queue entry freed without a status word");

endmodule

FILE: src/blob_edge_pan_tilt_tracker.sv
// top level of the blob edge pan/tilt tracker: register port, input stall, submodules
// depends on bept_pkg, bept_track and bept_servo

// Takes one pixel word per clock while the input is not stalled. A pixel is
// registered, folded into the edge points in the next cycle, and on the frame's
// last pixel the edge points are registered as a snapshot, from which the servo
// steps run and the frame's results enter the queue. Each frame yields one to
// three result words (pan command, tilt command, status), one per cycle from the
// output register while the receiver does not stall. Up to four finished frames
// wait in a frame result queue; the input stalls only while the queue and the
// frames still in the pipeline fill those four places, which happens when frames
// are shorter than their result words or when the receiver holds off.

module blob_edge_pan_tilt_tracker #(
  parameter int unsigned MAX_COLS = bept_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = bept_pkg::MaxRowsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bept_pkg::pix_t    in_data_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bept_pkg::result_t out_data_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  bept_pkg::cfg_t   cfg_q;
  bept_pkg::snap_t  snap;
  bept_pkg::reg_idx_e widx;
  logic             wr_en, accept, fe_busy;
  logic [2:0]       cnt;
  logic [3:0]       load_sum;

  // register writes
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = bept_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_col <= bept_pkg::CenterColRst;
      cfg_q.center_row <= bept_pkg::CenterRowRst;
      cfg_q.tolerance  <= bept_pkg::ToleranceRst;
      cfg_q.move_step  <= bept_pkg::MoveStepRst;
      cfg_q.pan_min    <= bept_pkg::PanMinRst;
      cfg_q.pan_max    <= bept_pkg::PanMaxRst;
      cfg_q.tilt_min   <= bept_pkg::TiltMinRst;
      cfg_q.tilt_max   <= bept_pkg::TiltMaxRst;
    end else if (wr_en) begin
      case (widx)
        bept_pkg::REG_CENTER_COL: cfg_q.center_col <= pwdata[9:0];
        bept_pkg::REG_CENTER_ROW: cfg_q.center_row <= pwdata[9:0];
        bept_pkg::REG_TOLERANCE:  cfg_q.tolerance  <= pwdata[7:0];
        bept_pkg::REG_MOVE_STEP:  cfg_q.move_step  <= pwdata[7:0];
        bept_pkg::REG_PAN_MIN:    cfg_q.pan_min    <= pwdata[11:0];
        bept_pkg::REG_PAN_MAX:    cfg_q.pan_max    <= pwdata[11:0];
        bept_pkg::REG_TILT_MIN:   cfg_q.tilt_min   <= pwdata[11:0];
        bept_pkg::REG_TILT_MAX:   cfg_q.tilt_max   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (widx)
      bept_pkg::REG_CENTER_COL: prdata = {22'b0, cfg_q.center_col};
      bept_pkg::REG_CENTER_ROW: prdata = {22'b0, cfg_q.center_row};
      bept_pkg::REG_TOLERANCE:  prdata = {24'b0, cfg_q.tolerance};
      bept_pkg::REG_MOVE_STEP:  prdata = {24'b0, cfg_q.move_step};
      bept_pkg::REG_PAN_MIN:    prdata = {20'b0, cfg_q.pan_min};
      bept_pkg::REG_PAN_MAX:    prdata = {20'b0, cfg_q.pan_max};
      bept_pkg::REG_TILT_MIN:   prdata = {20'b0, cfg_q.tilt_min};
      bept_pkg::REG_TILT_MAX:   prdata = {20'b0, cfg_q.tilt_max};
      default:                  prdata = '0;
    endcase
  end

  // stall while queued plus in-flight frames fill the queue
  assign load_sum   = {1'b0, cnt} + {3'b000, fe_busy} + {3'b000, snap.vld};
  assign in_stall_o = load_sum >= 4'(bept_pkg::QDepth);
  assign accept     = in_valid_i && !in_stall_o;

  bept_track #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .pix_i     (in_data_i),
    .fe_busy_o (fe_busy),
    .snap_o    (snap)
  );

  bept_servo u_servo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .snap_i      (snap),
    .cnt_o       (cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // the queue, the pipeline and the stall together never exceed the queue depth
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_sum <= 4'(bept_pkg::QDepth))
    else $error("frames in flight exceed queue room");

  a_fe_to_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_busy |=> snap.vld)
    else $error("frame end did not reach the servo stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt == 3'(bept_pkg::QDepth)) |-> in_stall_o)
    else $error("input open with a full queue");

endmodule
